/* rtl/ofrc_pkg.sv */
// Shared types and constants for the page-mode framebuffer refresh core.
`default_nettype none

package ofrc_pkg;

  // request opcodes
  localparam logic [2:0] OP_POINT         = 3'd0;
  localparam logic [2:0] OP_BLIT_START    = 3'd1;
  localparam logic [2:0] OP_BLIT_BYTE     = 3'd2;
  localparam logic [2:0] OP_CLEAR_REFRESH = 3'd3;
  localparam logic [2:0] OP_REFRESH       = 3'd4;
  localparam logic [2:0] OP_WRITE         = 3'd5;
  localparam logic [2:0] OP_PULL          = 3'd6;

  // link bytes
  localparam logic [7:0] CTRL_CMD      = 8'h00;
  localparam logic [7:0] CTRL_DATA     = 8'h40;
  localparam logic [7:0] CMD_PAGE_BASE = 8'hb0;
  localparam logic [7:0] CMD_COL_LO    = 8'h00;
  localparam logic [7:0] CMD_COL_HI    = 8'h10;

  // refresh step codes
  localparam logic [7:0] STEP_PAGE_CMD = 8'd1;
  localparam logic [7:0] STEP_COL_LO   = 8'd3;
  localparam logic [7:0] STEP_CMD_END  = 8'd6;
  localparam logic [7:0] STEP_DATA     = 8'd7;

  localparam int DISPLAY_COUNT = 2;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_W    = 2;
  localparam int FIFO_CNT_W    = 3;

  typedef struct packed {
    logic [2:0] opcode;
    logic [6:0] x_position;
    logic [5:0] y_position;
    logic [7:0] size_x;
    logic [6:0] size_y;
    logic       pixel_value;
    logic [7:0] bitmap_byte;
    logic       device;
    logic [7:0] payload_byte;
    logic       is_data;
  } item_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       out_device;
    logic       first_of_transfer;
    logic       last_of_transfer;
    logic       busy_error;
  } out_entry_t;

  typedef enum logic [2:0] {
    ASEL_CLEAR, ASEL_POINT, ASEL_BLIT0, ASEL_BLIT1, ASEL_PULL
  } addr_sel_e;

  typedef enum logic [2:0] {
    PUSH_NONE, PUSH_BUSY, PUSH_IDLE, PUSH_CTRL, PUSH_PAY, PUSH_REFRESH
  } push_sel_e;

  typedef enum logic {
    ARM_ITEM, ARM_BLIT
  } arm_src_e;

  typedef struct packed {
    logic      load;
    logic      mem_rd;
    logic      mem_wr;
    addr_sel_e addr_sel;
    logic      clr_step;
    push_sel_e push_sel;
    logic      arm;
    arm_src_e  arm_src;
    logic      refresh_adv;
    logic      blit_start;
    logic      blit_adv;
  } ofrc_cmd_t;

  typedef struct packed {
    logic       room;
    logic [2:0] opcode;
    logic       refresh_active;
    logic       refresh_needs_read;
    logic       blit_left_zero;
    logic       blit_left_one;
    logic       blit_start_empty;
    logic       clear_last;
  } ofrc_status_t;

endpackage

`default_nettype wire

/* rtl/ofrc_out_fifo.sv */
// Four-entry result queue in front of the output stream.
`default_nettype none

module ofrc_out_fifo (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     push_i,
  input  ofrc_pkg::out_entry_t    push_data_i,
  output logic                    room_o,
  output logic                    m_valid_o,
  input  wire                     m_ready_i,
  output ofrc_pkg::out_entry_t    m_data_o
);
  import ofrc_pkg::*;

  out_entry_t              fifo_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0]   cnt_q;
  logic                    pop;

  assign m_valid_o = (cnt_q != '0);
  assign m_data_o  = fifo_q[rd_ptr_q];
  assign pop       = m_valid_o && m_ready_i;
  assign room_o    = (cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));

  always_ff @(posedge clk_i) begin
    if (push_i) fifo_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)    rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({push_i, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != FIFO_CNT_W'(FIFO_DEPTH)))
    else $error("result queue overflow");

endmodule

`default_nettype wire

/* rtl/ofrc_datapath.sv */
// Frame memory, refresh and blit registers, and result byte formation.
`default_nettype none

module ofrc_datapath #(
  parameter int PANEL_WIDTH = 128,
  parameter int PAGE_COUNT  = 8
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  ofrc_pkg::item_t         item_i,
  input  ofrc_pkg::ofrc_cmd_t     cmd_i,
  input  wire                     room_i,
  output ofrc_pkg::ofrc_status_t  status_o,
  output logic                    push_o,
  output ofrc_pkg::out_entry_t    push_data_o
);
  import ofrc_pkg::*;

  localparam int DEPTH  = PAGE_COUNT * PANEL_WIDTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic DEV_MAX = 1'(DISPLAY_COUNT - 1);

  function automatic logic [ADDR_W-1:0] page_addr(logic [2:0] page, logic [6:0] col);
    page_addr = ADDR_W'(32'(page) * PANEL_WIDTH + 32'(col));
  endfunction

  item_t             item_q;
  logic [7:0]        frame_mem_q [DEPTH];
  logic [7:0]        rd_data_q;
  logic [ADDR_W-1:0] clr_q;

  logic        refresh_active_q;
  logic [2:0]  refresh_page_q;
  logic [7:0]  refresh_step_q;
  logic        refresh_target_q;

  logic [6:0]  blit_origin_q, blit_cur_q, blit_row_q;
  logic [7:0]  blit_width_q;
  logic [10:0] blit_left_q;
  logic        blit_mode_q, blit_target_q;

  logic        dev_sat;
  logic [7:0]  sx_sat;
  logic [6:0]  sy_sat;
  logic [3:0]  blit_pages;
  logic [10:0] blit_bytes;
  logic [7:0]  col_x;
  logic        col_ok, ok0, ok1, pt_ok;
  logic [3:0]  page0;
  logic [4:0]  page1;
  logic [2:0]  shift;
  logic [7:0]  blit_val, pt_mask, new0, new1, new_pt;
  logic [15:0] val16, mask16;
  logic [7:0]  cur_next;
  logic        page_done;

  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        mem_wdata;
  logic              mem_we;

  assign dev_sat = (32'(item_q.device) >= DISPLAY_COUNT) ? DEV_MAX : item_q.device;

  // blit geometry
  assign sx_sat     = (item_q.size_x > 8'd128) ? 8'd128 : item_q.size_x;
  assign sy_sat     = (item_q.size_y > 7'd64) ? 7'd64 : item_q.size_y;
  assign blit_pages = 4'((8'(sy_sat) + 8'd7) >> 3);
  assign blit_bytes = 11'(sx_sat) * 11'(blit_pages);

  assign col_x  = 8'(blit_origin_q) + 8'(blit_cur_q);
  assign col_ok = 9'(col_x) < 9'(PANEL_WIDTH);
  assign page0  = blit_row_q[6:3];
  assign page1  = 5'(page0) + 5'd1;
  assign shift  = blit_row_q[2:0];
  assign ok0    = col_ok && (5'(page0) < 5'(PAGE_COUNT));
  assign ok1    = col_ok && (shift != 3'd0) && (page1 < 5'(PAGE_COUNT));

  assign blit_val = item_q.bitmap_byte ^ {8{~blit_mode_q}};
  assign val16    = 16'(blit_val) << shift;
  assign mask16   = 16'h00ff << shift;
  assign new0     = (rd_data_q & ~mask16[7:0]) | val16[7:0];
  assign new1     = (rd_data_q & ~mask16[15:8]) | val16[15:8];

  // single point
  assign pt_ok   = (8'(item_q.x_position) < 8'(PANEL_WIDTH)) &&
                   (7'(item_q.y_position) < 7'(PAGE_COUNT * 8));
  assign pt_mask = 8'd1 << item_q.y_position[2:0];
  assign new_pt  = item_q.pixel_value ? (rd_data_q | pt_mask) : (rd_data_q & ~pt_mask);

  assign page_done = (9'(refresh_step_q) >= 9'(PANEL_WIDTH + 6));
  assign cur_next  = 8'(blit_cur_q) + 8'd1;

  always_comb begin
    mem_addr  = clr_q;
    mem_wdata = 8'h00;
    mem_we    = 1'b0;
    case (cmd_i.addr_sel)
      ASEL_CLEAR: begin
        mem_we = cmd_i.mem_wr;
      end
      ASEL_POINT: begin
        mem_addr  = page_addr(item_q.y_position[5:3], item_q.x_position);
        mem_wdata = new_pt;
        mem_we    = cmd_i.mem_wr && pt_ok;
      end
      ASEL_BLIT0: begin
        mem_addr  = page_addr(page0[2:0], col_x[6:0]);
        mem_wdata = new0;
        mem_we    = cmd_i.mem_wr && ok0;
      end
      ASEL_BLIT1: begin
        mem_addr  = page_addr(page1[2:0], col_x[6:0]);
        mem_wdata = new1;
        mem_we    = cmd_i.mem_wr && ok1;
      end
      ASEL_PULL: begin
        mem_addr = page_addr(refresh_page_q, 7'(refresh_step_q - STEP_DATA));
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) frame_mem_q[mem_addr] <= mem_wdata;
    if (cmd_i.mem_rd) rd_data_q <= frame_mem_q[mem_addr];
    if (cmd_i.load) item_q <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q            <= '0;
      refresh_active_q <= 1'b0;
      refresh_page_q   <= '0;
      refresh_step_q   <= '0;
      refresh_target_q <= 1'b0;
      blit_origin_q    <= '0;
      blit_cur_q       <= '0;
      blit_row_q       <= '0;
      blit_width_q     <= '0;
      blit_left_q      <= '0;
      blit_mode_q      <= 1'b0;
      blit_target_q    <= 1'b0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_q <= status_o.clear_last ? '0 : clr_q + 1'b1;
      end
      if (cmd_i.arm) begin
        refresh_active_q <= 1'b1;
        refresh_page_q   <= '0;
        refresh_step_q   <= '0;
        refresh_target_q <= (cmd_i.arm_src == ARM_BLIT) ? blit_target_q : dev_sat;
      end else if (cmd_i.refresh_adv) begin
        if (page_done) begin
          refresh_step_q <= '0;
          if (32'(refresh_page_q) + 1 >= PAGE_COUNT) begin
            refresh_active_q <= 1'b0;
            refresh_page_q   <= '0;
          end else begin
            refresh_page_q <= refresh_page_q + 3'd1;
          end
        end else begin
          refresh_step_q <= refresh_step_q + 8'd1;
        end
      end
      if (cmd_i.blit_start) begin
        blit_origin_q <= item_q.x_position;
        blit_cur_q    <= '0;
        blit_row_q    <= 7'(item_q.y_position);
        blit_width_q  <= sx_sat;
        blit_left_q   <= blit_bytes;
        blit_mode_q   <= item_q.pixel_value;
        blit_target_q <= dev_sat;
      end else if (cmd_i.blit_adv) begin
        if (cur_next >= blit_width_q) begin
          blit_cur_q <= '0;
          blit_row_q <= blit_row_q + 7'd8;
        end else begin
          blit_cur_q <= cur_next[6:0];
        end
        blit_left_q <= blit_left_q - 11'd1;
      end
    end
  end

  // result formation
  always_comb begin
    push_data_o = '0;
    push_o      = (cmd_i.push_sel != PUSH_NONE);
    case (cmd_i.push_sel)
      PUSH_BUSY: begin
        push_data_o.busy_error = 1'b1;
      end
      PUSH_CTRL: begin
        push_data_o.byte_valid        = 1'b1;
        push_data_o.out_byte          = item_q.is_data ? CTRL_DATA : CTRL_CMD;
        push_data_o.out_device        = dev_sat;
        push_data_o.first_of_transfer = 1'b1;
      end
      PUSH_PAY: begin
        push_data_o.byte_valid       = 1'b1;
        push_data_o.out_byte         = item_q.payload_byte;
        push_data_o.out_device       = dev_sat;
        push_data_o.last_of_transfer = 1'b1;
      end
      PUSH_REFRESH: begin
        push_data_o.byte_valid = 1'b1;
        push_data_o.out_device = refresh_target_q;
        if (refresh_step_q < STEP_CMD_END) begin
          if (!refresh_step_q[0]) begin
            push_data_o.out_byte          = CTRL_CMD;
            push_data_o.first_of_transfer = 1'b1;
          end else begin
            push_data_o.last_of_transfer = 1'b1;
            if (refresh_step_q == STEP_PAGE_CMD) begin
              push_data_o.out_byte = CMD_PAGE_BASE + 8'(refresh_page_q);
            end else if (refresh_step_q == STEP_COL_LO) begin
              push_data_o.out_byte = CMD_COL_LO;
            end else begin
              push_data_o.out_byte = CMD_COL_HI;
            end
          end
        end else if (refresh_step_q == STEP_CMD_END) begin
          push_data_o.out_byte          = CTRL_DATA;
          push_data_o.first_of_transfer = 1'b1;
        end else begin
          push_data_o.out_byte         = rd_data_q;
          push_data_o.last_of_transfer = page_done;
        end
      end
      default: begin
        push_data_o = '0;
      end
    endcase
  end

  always_comb begin
    status_o                    = '0;
    status_o.room               = room_i;
    status_o.opcode             = item_q.opcode;
    status_o.refresh_active     = refresh_active_q;
    status_o.refresh_needs_read = (refresh_step_q >= STEP_DATA);
    status_o.blit_left_zero     = (blit_left_q == 11'd0);
    status_o.blit_left_one      = (blit_left_q == 11'd1);
    status_o.blit_start_empty   = (blit_bytes == 11'd0);
    status_o.clear_last         = (clr_q == ADDR_W'(DEPTH - 1));
  end

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    refresh_active_q |-> (9'(refresh_step_q) < 9'(PANEL_WIDTH + 7)))
    else $error("refresh step past end of page");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !refresh_active_q |-> (refresh_step_q == '0 && refresh_page_q == '0))
    else $error("refresh counters not parked while idle");

  a_blit_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.blit_adv |-> (blit_left_q != 11'd0))
    else $error("blit advanced with no bytes left");

endmodule

`default_nettype wire

/* rtl/ofrc_ctrl.sv */
// Request sequencer: clear pass, read-modify-write and result push control.
`default_nettype none

module ofrc_ctrl (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     s_valid_i,
  output logic                    s_ready_o,
  input  ofrc_pkg::ofrc_status_t  status_i,
  output ofrc_pkg::ofrc_cmd_t     cmd_o
);
  import ofrc_pkg::*;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_EXEC, S_WR0, S_RD1, S_WR1, S_CLR, S_PAY, S_PULL
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o     = '0;
    state_d   = state_q;
    s_ready_o = 1'b0;
    case (state_q)
      S_INIT: begin
        cmd_o.addr_sel = ASEL_CLEAR;
        cmd_o.mem_wr   = 1'b1;
        cmd_o.clr_step = 1'b1;
        if (status_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        s_ready_o = status_i.room;
        if (s_valid_i && status_i.room) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        case (status_i.opcode)
          OP_POINT: begin
            cmd_o.mem_rd   = 1'b1;
            cmd_o.addr_sel = ASEL_POINT;
            state_d        = S_WR0;
          end
          OP_BLIT_START: begin
            cmd_o.blit_start = 1'b1;
            if (status_i.blit_start_empty) begin
              if (status_i.refresh_active) cmd_o.push_sel = PUSH_BUSY;
              else cmd_o.arm = 1'b1;
            end
          end
          OP_BLIT_BYTE: begin
            if (!status_i.blit_left_zero) begin
              cmd_o.mem_rd   = 1'b1;
              cmd_o.addr_sel = ASEL_BLIT0;
              state_d        = S_WR0;
            end
          end
          OP_CLEAR_REFRESH: begin
            if (status_i.refresh_active) cmd_o.push_sel = PUSH_BUSY;
            else state_d = S_CLR;
          end
          OP_REFRESH: begin
            if (status_i.refresh_active) cmd_o.push_sel = PUSH_BUSY;
            else cmd_o.arm = 1'b1;
          end
          OP_WRITE: begin
            if (status_i.refresh_active) begin
              cmd_o.push_sel = PUSH_BUSY;
            end else begin
              cmd_o.push_sel = PUSH_CTRL;
              state_d        = S_PAY;
            end
          end
          OP_PULL: begin
            if (!status_i.refresh_active) begin
              cmd_o.push_sel = PUSH_IDLE;
            end else if (status_i.refresh_needs_read) begin
              cmd_o.mem_rd   = 1'b1;
              cmd_o.addr_sel = ASEL_PULL;
              state_d        = S_PULL;
            end else begin
              cmd_o.push_sel    = PUSH_REFRESH;
              cmd_o.refresh_adv = 1'b1;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_WR0: begin
        cmd_o.mem_wr   = 1'b1;
        cmd_o.addr_sel = (status_i.opcode == OP_POINT) ? ASEL_POINT : ASEL_BLIT0;
        state_d        = (status_i.opcode == OP_BLIT_BYTE) ? S_RD1 : S_IDLE;
      end
      S_RD1: begin
        cmd_o.mem_rd   = 1'b1;
        cmd_o.addr_sel = ASEL_BLIT1;
        state_d        = S_WR1;
      end
      S_WR1: begin
        cmd_o.mem_wr   = 1'b1;
        cmd_o.addr_sel = ASEL_BLIT1;
        cmd_o.blit_adv = 1'b1;
        if (status_i.blit_left_one) begin
          if (status_i.refresh_active) begin
            cmd_o.push_sel = PUSH_BUSY;
          end else begin
            cmd_o.arm     = 1'b1;
            cmd_o.arm_src = ARM_BLIT;
          end
        end
        state_d = S_IDLE;
      end
      S_CLR: begin
        cmd_o.addr_sel = ASEL_CLEAR;
        cmd_o.mem_wr   = 1'b1;
        cmd_o.clr_step = 1'b1;
        if (status_i.clear_last) begin
          cmd_o.arm = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_PAY: begin
        cmd_o.push_sel = PUSH_PAY;
        state_d        = S_IDLE;
      end
      S_PULL: begin
        cmd_o.push_sel    = PUSH_REFRESH;
        cmd_o.refresh_adv = 1'b1;
        state_d           = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/oled_page_framebuffer_refresh_core.sv */
// Top level of the page-mode monochrome framebuffer and refresh byte streamer.
//
// Requests enter on the s_axis channel: tuser carries the opcode and the
// data/command flag, tdata the drawing and write fields. Results leave on
// m_axis as link bytes or status words; tlast closes a link transfer.
// Points, blits, clears and refreshes give no result; a blit, clear or
// refresh met by a running refresh is refused with one busy word, as is a
// write, which else gives two bytes. Every pull gives one byte, or an empty
// word when no refresh is armed. One request is worked at a time: a point
// reads then writes its byte, a blit byte reads and writes on its first page
// and then on the next, a pixel byte is read before it is pulled, a write
// pushes its control byte and then its payload, and a clear writes every
// frame memory byte. The single-port frame memory takes one read or one
// write a cycle, so a pixel update is a read followed by a write. A result
// is pushed from the execute state, or for a pulled pixel byte, a write
// payload or a finishing blit byte from the state that ends the request.
// After reset the frame memory is zeroed in a pass over all of its
// PAGE_COUNT*PANEL_WIDTH bytes (1024 by default), during which no request
// is taken. Results wait in a four-entry queue; a stalled receiver holds
// them there and requests are taken only while two places remain free.
`default_nettype none

module oled_page_framebuffer_refresh_core #(
  parameter int PANEL_WIDTH = 128,
  parameter int PAGE_COUNT  = 8
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // [6:0] x_position, [12:7] y_position, [20:13] size_x, [27:21] size_y,
  // [28] pixel_value, [36:29] bitmap_byte, [37] device, [45:38] payload_byte
  input  wire  [47:0] s_axis_tdata,
  // [2:0] opcode, [3] is_data
  input  wire  [7:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // [7:0] out_byte, [8] out_device
  output logic [15:0] m_axis_tdata,
  // [0] byte_valid, [1] first_of_transfer, [2] busy_error
  output logic [7:0]  m_axis_tuser,
  // last_of_transfer
  output logic        m_axis_tlast
);
  import ofrc_pkg::*;

  item_t        item;
  ofrc_cmd_t    cmd;
  ofrc_status_t status;
  logic         room;
  logic         push;
  out_entry_t   push_data;
  out_entry_t   head;

  always_comb begin
    item.opcode       = s_axis_tuser[2:0];
    item.is_data      = s_axis_tuser[3];
    item.x_position   = s_axis_tdata[6:0];
    item.y_position   = s_axis_tdata[12:7];
    item.size_x       = s_axis_tdata[20:13];
    item.size_y       = s_axis_tdata[27:21];
    item.pixel_value  = s_axis_tdata[28];
    item.bitmap_byte  = s_axis_tdata[36:29];
    item.device       = s_axis_tdata[37];
    item.payload_byte = s_axis_tdata[45:38];
  end

  ofrc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  ofrc_datapath #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PAGE_COUNT  (PAGE_COUNT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .cmd_i       (cmd),
    .room_i      (room),
    .status_o    (status),
    .push_o      (push),
    .push_data_o (push_data)
  );

  ofrc_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .room_o      (room),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (head)
  );

  assign m_axis_tdata = {7'd0, head.out_device, head.out_byte};
  assign m_axis_tuser = {5'd0, head.busy_error, head.first_of_transfer, head.byte_valid};
  assign m_axis_tlast = head.last_of_transfer;

endmodule

`default_nettype wire
